// ===== rtl/rrhs_pkg.sv =====
`default_nettype none
package rrhs_pkg;

	localparam int MAX_POINTS   = 256;
	localparam int ADDR_W       = $clog2(MAX_POINTS);
	localparam int CNT_W        = $clog2(MAX_POINTS + 1);
	localparam int COORD_W      = 16;
	localparam int PT_W         = 2 * COORD_W;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_SH      = 14;
	localparam int CX_W         = COORD_W + ATAN_SH + 4;
	localparam int ANG_W        = 25;
	localparam int C_W          = 31;
	localparam int FRAC_CS      = 28;
	localparam int PROD_W       = C_W + COORD_W;
	localparam int ACC_W        = PROD_W + 1;
	localparam int ROT_W        = ACC_W - FRAC_CS;
	localparam int YAW_W        = ANG_W - 7;
	localparam int THR_W        = 15;
	localparam int THR2_W       = 2 * THR_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(3294199);
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(1647100);
	localparam logic signed [CX_W-1:0]  GAIN_Q28    = CX_W'(163008218);

	typedef enum logic [1:0] {
		OP_LOAD_SRC   = 2'd0,
		OP_LOAD_TGT   = 2'd1,
		OP_HYPOTHESIS = 2'd2,
		OP_FINISH     = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd2;

	typedef struct packed {
		logic                    go;
		logic                    rotate;
		logic signed [CX_W-1:0]  x;
		logic signed [CX_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
	} cordic_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [CX_W-1:0]  x;
		logic signed [CX_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
	} cordic_rsp_t;

	// arctan(2^-i) in units of 2^-20 rad
	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0:  v = ANG_W'(823550);
			5'd1:  v = ANG_W'(486170);
			5'd2:  v = ANG_W'(256879);
			5'd3:  v = ANG_W'(130396);
			5'd4:  v = ANG_W'(65451);
			5'd5:  v = ANG_W'(32757);
			5'd6:  v = ANG_W'(16383);
			5'd7:  v = ANG_W'(8192);
			5'd8:  v = ANG_W'(4096);
			5'd9:  v = ANG_W'(2048);
			5'd10: v = ANG_W'(1024);
			5'd11: v = ANG_W'(512);
			5'd12: v = ANG_W'(256);
			5'd13: v = ANG_W'(128);
			5'd14: v = ANG_W'(64);
			5'd15: v = ANG_W'(32);
			5'd16: v = ANG_W'(16);
			5'd17: v = ANG_W'(8);
			5'd18: v = ANG_W'(4);
			5'd19: v = ANG_W'(2);
			5'd20: v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ransac_rigid2d_hypothesis_scorer.sv =====
// loads and finish leave the block idle and may follow back to back; finish gives its result
// on the done strobe in the next cycle, and the receiver cannot stall it
// a hypothesis holds busy while it runs over the points in use (ns, nt),
// with a fold step per half turn of the yaw; its pace is set by one target
// compare per cycle and the shared cordic
// reset clears the best pose and count and restores the registers (threshold 51, counts 256);
// the point stores are not cleared
`default_nettype none
module ransac_rigid2d_hypothesis_scorer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [1:0]                           operation,
	input  wire logic signed [rrhs_pkg::COORD_W-1:0]  point_x,
	input  wire logic signed [rrhs_pkg::COORD_W-1:0]  point_y,
	input  wire logic [rrhs_pkg::ADDR_W-1:0]          slot,
	input  wire logic [rrhs_pkg::ADDR_W-1:0]          src_first,
	input  wire logic [rrhs_pkg::ADDR_W-1:0]          src_second,
	input  wire logic [rrhs_pkg::ADDR_W-1:0]          tgt_first,
	input  wire logic [rrhs_pkg::ADDR_W-1:0]          tgt_second,
	output logic                                      done,
	output logic signed [rrhs_pkg::COORD_W-1:0]       pose_x,
	output logic signed [rrhs_pkg::COORD_W-1:0]       pose_y,
	output logic signed [rrhs_pkg::COORD_W-1:0]       pose_yaw,
	output logic [rrhs_pkg::CNT_W-1:0]                inlier_count,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rrhs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rrhs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rrhs_pkg::*;

	localparam int DIFF_W = COORD_W + 1;
	localparam int DX_W   = ROT_W + 1;
	localparam int SQ_W   = 2 * DX_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic signed [ROT_W:0] SAT_HI = (ROT_W+1)'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [ROT_W:0] SAT_LO = -SAT_HI - (ROT_W+1)'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_AT, S_AT_W, S_YAW, S_FOLD,
		S_SC_W, S_ROT, S_POST, S_SRD, S_SLAT, S_SCAN, S_NEXT, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [THR_W-1:0]  thr_q;
	logic [THR2_W-1:0] thr2_q;
	logic [CNT_W-1:0]  src_cnt_q, tgt_cnt_q, ns, nt;

	// hypothesis setup
	logic [ADDR_W-1:0]        a_q, b_q, j_q, k_q;
	logic signed [COORD_W-1:0] pax_q, pay_q, qjx_q, qjy_q;
	logic signed [DIFF_W-1:0] dpx_q, dpy_q, dqx_q, dqy_q, at_x, at_y;
	logic                     sel_q, at_zero;
	logic signed [ANG_W-1:0]  ap_q, aq_q, zf_q;
	logic signed [ANG_W:0]    ang_diff, ang_rnd;
	logic signed [YAW_W-1:0]  yaw_q;
	logic                     flip_q;
	logic signed [C_W-1:0]    c_q, s_q, cx_t, sx_t;
	logic signed [CX_W-1:0]   at_xe, at_ye;

	// rotation through the shared multiplier
	logic signed [COORD_W-1:0] rot_px_q, rot_py_q, mul_b;
	logic signed [C_W-1:0]     mul_a;
	logic [2:0]                rstep_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   acc_q, rnd_x, rnd_y;
	logic signed [ROT_W-1:0]   rot_x_q, rot_y_q;
	logic                      pose_q;
	logic signed [COORD_W-1:0] tx_q, ty_q;
	logic signed [ROT_W:0]     tx_d, ty_d;

	// scoring scan
	logic signed [ROT_W-1:0]  rx_q, ry_q;
	logic [CNT_W-1:0]         m_q, n_q, inl_q;
	logic                     hit_q, v_s1, v_s2, v_s3, issuing, in_rad;
	logic signed [DX_W-1:0]   dx_s2, dy_s2;
	logic [SQ_W-1:0]          sqx_s3, sqy_s3;

	// best pose and result
	logic signed [COORD_W-1:0] best_x_q, best_y_q;
	logic signed [YAW_W-1:0]   best_yaw_q;
	logic [CNT_W-1:0]          best_inl_q;
	logic                      done_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q, out_yaw_q;
	logic [CNT_W-1:0]          out_cnt_q;

	// point stores
	logic                      accept, hyp_ok;
	op_t                       op_in;
	logic                      src_we, tgt_we;
	logic [ADDR_W-1:0]         src_raddr, tgt_raddr;
	logic [PT_W-1:0]           src_rdata, tgt_rdata;
	logic signed [COORD_W-1:0] sx, sy, tgx, tgy;

	cordic_req_t creq;
	cordic_rsp_t crsp;

	assign op_in     = op_t'(operation);
	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// counts above the store size act as the store size
	assign ns = (src_cnt_q > CNT_MAX) ? CNT_MAX : src_cnt_q;
	assign nt = (tgt_cnt_q > CNT_MAX) ? CNT_MAX : tgt_cnt_q;

	// equal or out-of-range indices skip the hypothesis
	assign hyp_ok = (src_first != src_second) && (tgt_first != tgt_second) &&
		(CNT_W'(src_first) < ns) && (CNT_W'(src_second) < ns) &&
		(CNT_W'(tgt_first) < nt) && (CNT_W'(tgt_second) < nt);

	assign src_we = accept && (op_in == OP_LOAD_SRC);
	assign tgt_we = accept && (op_in == OP_LOAD_TGT);

	always_comb begin
		unique case (state_q)
			S_RD0:   src_raddr = a_q;
			S_RD1:   src_raddr = b_q;
			default: src_raddr = m_q[ADDR_W-1:0];
		endcase
		unique case (state_q)
			S_RD0:   tgt_raddr = j_q;
			S_RD1:   tgt_raddr = k_q;
			default: tgt_raddr = n_q[ADDR_W-1:0];
		endcase
	end

	rrhs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (slot),
		.wdata ({point_y, point_x}),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	rrhs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (slot),
		.wdata ({point_y, point_x}),
		.raddr (tgt_raddr),
		.rdata (tgt_rdata)
	);

	assign sx  = src_rdata[COORD_W-1:0];
	assign sy  = src_rdata[PT_W-1:COORD_W];
	assign tgx = tgt_rdata[COORD_W-1:0];
	assign tgy = tgt_rdata[PT_W-1:COORD_W];

	// atan2 operands: fold a left half-plane segment by a half turn, then scale by 2^14
	assign at_x    = sel_q ? dqx_q : dpx_q;
	assign at_y    = sel_q ? dqy_q : dpy_q;
	assign at_zero = (at_x == '0) && (at_y == '0);
	assign at_xe   = CX_W'(at_x);
	assign at_ye   = CX_W'(at_y);

	always_comb begin
		creq.go     = 1'b0;
		creq.rotate = 1'b0;
		creq.x      = GAIN_Q28;
		creq.y      = '0;
		creq.z      = zf_q;
		if (state_q == S_AT) begin
			creq.go = !at_zero;
			if (at_x[DIFF_W-1]) begin
				creq.x = (-at_xe) <<< ATAN_SH;
				creq.y = (-at_ye) <<< ATAN_SH;
				creq.z = at_y[DIFF_W-1] ? -ANG_PI : ANG_PI;
			end else begin
				creq.x = at_xe <<< ATAN_SH;
				creq.y = at_ye <<< ATAN_SH;
				creq.z = '0;
			end
		end else if (state_q == S_FOLD) begin
			creq.go     = (zf_q <= ANG_HALF_PI) && (zf_q >= -ANG_HALF_PI);
			creq.rotate = 1'b1;
		end
	end

	rrhs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	// yaw rounded half up to Q4.12, then back to cordic angle units
	assign ang_diff = (ANG_W+1)'(aq_q) - (ANG_W+1)'(ap_q);
	assign ang_rnd  = ang_diff + (ANG_W+1)'(128);

	assign cx_t = C_W'(crsp.x);
	assign sx_t = C_W'(crsp.y);

	// multiplier operand order: c*px, s*py, s*px, c*py
	assign mul_a = (rstep_q == 3'd0 || rstep_q == 3'd3) ? c_q : s_q;
	assign mul_b = (rstep_q == 3'd0 || rstep_q == 3'd2) ? rot_px_q : rot_py_q;
	assign rnd_x = acc_q - ACC_W'(prod_s1) + (ACC_W'(1) <<< (FRAC_CS - 1));
	assign rnd_y = acc_q + ACC_W'(prod_s1) + (ACC_W'(1) <<< (FRAC_CS - 1));

	assign tx_d = (ROT_W+1)'(qjx_q) - (ROT_W+1)'(rot_x_q);
	assign ty_d = (ROT_W+1)'(qjy_q) - (ROT_W+1)'(rot_y_q);

	assign issuing = (state_q == S_SCAN) && (n_q < nt);
	assign in_rad  = ((SQ_W+1)'(sqx_s3) + (SQ_W+1)'(sqy_s3)) < (SQ_W+1)'(thr2_q);

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ROT_W:0] v);
		logic signed [ROT_W:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r[COORD_W-1:0];
	endfunction

	// datapath registers
	always_ff @(posedge clk) begin
		thr2_q  <= THR2_W'(thr_q * thr_q);
		prod_s1 <= mul_a * mul_b;
		if (state_q == S_ROT) begin
			case (rstep_q)
				3'd1: acc_q <= ACC_W'(prod_s1);
				3'd2: rot_x_q <= rnd_x[ACC_W-1:FRAC_CS];
				3'd3: acc_q <= ACC_W'(prod_s1);
				3'd4: rot_y_q <= rnd_y[ACC_W-1:FRAC_CS];
				default: ;
			endcase
		end
		// target compare pipeline: difference, squares, then sum against the limit
		dx_s2  <= DX_W'(rx_q) - DX_W'(tgx);
		dy_s2  <= DX_W'(ry_q) - DX_W'(tgy);
		sqx_s3 <= SQ_W'(dx_s2 * dx_s2);
		sqy_s3 <= SQ_W'(dy_s2 * dy_s2);
	end

	// sequencer, configuration, best pose and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			thr_q      <= THR_W'(51);
			src_cnt_q  <= CNT_MAX;
			tgt_cnt_q  <= CNT_MAX;
			best_x_q   <= '0;
			best_y_q   <= '0;
			best_yaw_q <= '0;
			best_inl_q <= '0;
			done_q     <= 1'b0;
			m_q        <= '0;
			n_q        <= '0;
			inl_q      <= '0;
			hit_q      <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			sel_q      <= 1'b0;
			flip_q     <= 1'b0;
			pose_q     <= 1'b0;
			rstep_q    <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issuing;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			if (v_s3 && in_rad) begin
				hit_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_THRESHOLD:    thr_q <= cfg_data[THR_W-1:0];
					CFG_SOURCE_COUNT: src_cnt_q <= cfg_data[CNT_W-1:0];
					CFG_TARGET_COUNT: tgt_cnt_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op_in == OP_HYPOTHESIS && hyp_ok) begin
							a_q     <= src_first;
							b_q     <= src_second;
							j_q     <= tgt_first;
							k_q     <= tgt_second;
							state_q <= S_RD0;
						end else if (op_in == OP_FINISH) begin
							out_x_q    <= best_x_q;
							out_y_q    <= best_y_q;
							out_yaw_q  <= best_yaw_q[COORD_W-1:0];
							out_cnt_q  <= best_inl_q;
							done_q     <= 1'b1;
							best_x_q   <= '0;
							best_y_q   <= '0;
							best_yaw_q <= '0;
							best_inl_q <= '0;
						end
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					pax_q    <= sx;
					pay_q    <= sy;
					rot_px_q <= sx;
					rot_py_q <= sy;
					qjx_q    <= tgx;
					qjy_q    <= tgy;
					state_q  <= S_RD2;
				end
				S_RD2: begin
					dpx_q   <= DIFF_W'(sx) - DIFF_W'(pax_q);
					dpy_q   <= DIFF_W'(sy) - DIFF_W'(pay_q);
					dqx_q   <= DIFF_W'(tgx) - DIFF_W'(qjx_q);
					dqy_q   <= DIFF_W'(tgy) - DIFF_W'(qjy_q);
					sel_q   <= 1'b0;
					state_q <= S_AT;
				end
				S_AT: begin
					// a zero-length segment has angle zero
					if (at_zero) begin
						if (sel_q) begin
							aq_q    <= '0;
							state_q <= S_YAW;
						end else begin
							ap_q  <= '0;
							sel_q <= 1'b1;
						end
					end else begin
						state_q <= S_AT_W;
					end
				end
				S_AT_W: begin
					if (crsp.done) begin
						if (sel_q) begin
							aq_q    <= crsp.z;
							state_q <= S_YAW;
						end else begin
							ap_q    <= crsp.z;
							sel_q   <= 1'b1;
							state_q <= S_AT;
						end
					end
				end
				S_YAW: begin
					yaw_q   <= ang_rnd[ANG_W:8];
					zf_q    <= ANG_W'({ang_rnd[ANG_W:8], 8'd0});
					flip_q  <= 1'b0;
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					// bring the angle into [-pi/2, pi/2] a half turn at a time
					if (zf_q > ANG_HALF_PI) begin
						zf_q   <= zf_q - ANG_PI;
						flip_q <= !flip_q;
					end else if (zf_q < -ANG_HALF_PI) begin
						zf_q   <= zf_q + ANG_PI;
						flip_q <= !flip_q;
					end else begin
						state_q <= S_SC_W;
					end
				end
				S_SC_W: begin
					if (crsp.done) begin
						c_q     <= flip_q ? -cx_t : cx_t;
						s_q     <= flip_q ? -sx_t : sx_t;
						rstep_q <= '0;
						pose_q  <= 1'b1;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					rstep_q <= rstep_q + 3'd1;
					if (rstep_q == 3'd4) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (pose_q) begin
						// translation is q1 minus the rotated p1, saturated
						tx_q    <= sat_coord(tx_d);
						ty_q    <= sat_coord(ty_d);
						pose_q  <= 1'b0;
						m_q     <= '0;
						inl_q   <= '0;
						state_q <= S_SRD;
					end else begin
						rx_q    <= rot_x_q + ROT_W'(tx_q);
						ry_q    <= rot_y_q + ROT_W'(ty_q);
						n_q     <= '0;
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SRD: state_q <= S_SLAT;
				S_SLAT: begin
					rot_px_q <= sx;
					rot_py_q <= sy;
					rstep_q  <= '0;
					state_q  <= S_ROT;
				end
				S_SCAN: begin
					if (issuing) begin
						n_q <= n_q + 1'b1;
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// a source point with any target inside the radius is one inlier
					if (hit_q) begin
						inl_q <= inl_q + 1'b1;
					end
					m_q <= m_q + 1'b1;
					if (m_q + 1'b1 == ns) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_DONE: begin
					// ties keep the earlier pose
					if (inl_q > best_inl_q) begin
						best_inl_q <= inl_q;
						best_x_q   <= tx_q;
						best_y_q   <= ty_q;
						best_yaw_q <= yaw_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign pose_x       = out_x_q;
	assign pose_y       = out_y_q;
	assign pose_yaw     = out_yaw_q;
	assign inlier_count = out_cnt_q;

	// a result is only produced while the sequencer is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a hypothesis runs");

	// the best count only grows, or is cleared by a finish
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(best_inl_q != $past(best_inl_q)) |->
			((best_inl_q > $past(best_inl_q)) || (best_inl_q == '0)))
		else $error("best inlier count dropped without a finish");

	// each scanned source point adds at most one inlier
	a_inl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inl_q <= m_q)
		else $error("inlier count exceeds points scanned");

	// the cordic answers only when the sequencer waits for it
	a_cordic_wait: assert property (@(posedge clk) disable iff (!arst_n)
		crsp.done |-> (state_q == S_AT_W || state_q == S_SC_W))
		else $error("cordic result with no request pending");

endmodule
`default_nettype wire

// ===== rtl/rrhs_ram.sv =====
`default_nettype none
module rrhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/rrhs_cordic.sv =====
`default_nettype none
module rrhs_cordic (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rrhs_pkg::cordic_req_t req,
	output rrhs_pkg::cordic_rsp_t      rsp
);
	import rrhs_pkg::*;

	logic signed [CX_W-1:0]  x_q, y_q, x_sh, y_sh;
	logic signed [ANG_W-1:0] z_q, ang;
	logic [STEP_W-1:0]       step_q;
	logic                    run_q, rot_q, done_q, cw;

	assign x_sh = x_q >>> step_q;
	assign y_sh = y_q >>> step_q;
	assign ang  = atan_entry(5'(step_q));
	// vectoring with y above zero turns the same way as rotation with z below zero
	assign cw   = rot_q ? z_q[ANG_W-1] : (y_q > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rot_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				rot_q  <= req.rotate;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			x_q <= req.x;
			y_q <= req.y;
			z_q <= req.z;
		end else if (run_q) begin
			if (cw) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - ang;
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.x    = x_q;
		rsp.y    = y_q;
		rsp.z    = z_q;
	end

endmodule
`default_nettype wire

// ===== verif/ransac_rigid2d_hypothesis_scorer_tb.sv =====
`default_nettype none
module ransac_rigid2d_hypothesis_scorer_tb;
	import rrhs_pkg::*;

	// one finish result as it should appear on the result ports
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] yaw;
		logic [8:0]         count;
	} pose_t;

	// scoreboard: keeps its own copy of the point stores, registers and best pose
	class pose_scoreboard;
		int          src_pt[256][2];
		int          tgt_pt[256][2];
		longint      best_x, best_y, best_yaw;
		int          best_count;
		int          thresh, n_src, n_tgt;
		pose_t       pending[$];
		int          errors;
		longint      atan_lut[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
			8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

		function new();
			best_x = 0;
			best_y = 0;
			best_yaw = 0;
			best_count = 0;
			thresh = 51;
			n_src = 256;
			n_tgt = 256;
			errors = 0;
		endfunction

		function longint rnd_shift(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint clamp16(longint v);
			return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
		endfunction

		// vectoring cordic, angle in 2^-20 rad
		function longint seg_angle(longint dy, longint dx);
			longint z, nx, ny;
			z = 0;
			if (dx == 0 && dy == 0)
				return 0;
			if (dx < 0) begin
				z = (dy >= 0) ? 3294199 : -3294199;
				dx = -dx;
				dy = -dy;
			end
			dx = dx * 16384;
			dy = dy * 16384;
			for (int i = 0; i < 16; i++) begin
				if (dy > 0) begin
					nx = dx + (dy >>> i);
					ny = dy - (dx >>> i);
					z += atan_lut[i];
				end else begin
					nx = dx - (dy >>> i);
					ny = dy + (dx >>> i);
					z -= atan_lut[i];
				end
				dx = nx;
				dy = ny;
			end
			return z;
		endfunction

		// rotation cordic, cos and sin in Q2.28
		function void yaw_to_cs(longint yaw, output longint c, output longint s);
			longint z, cx, sy, nx, ny;
			bit     flip;
			z = yaw * 256;
			cx = 163008218;
			sy = 0;
			flip = 0;
			while (z > 1647100) begin z -= 3294199; flip = !flip; end
			while (z < -1647100) begin z += 3294199; flip = !flip; end
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = cx - (sy >>> i);
					ny = sy + (cx >>> i);
					z -= atan_lut[i];
				end else begin
					nx = cx + (sy >>> i);
					ny = sy - (cx >>> i);
					z += atan_lut[i];
				end
				cx = nx;
				sy = ny;
			end
			c = flip ? -cx : cx;
			s = flip ? -sy : sy;
		endfunction

		function void score(int a, int b, int j, int k);
			int     ns, nt, hits;
			longint ap, aq, yaw, c, s, tx, ty, thr2, px, py, rx, ry, dx, dy;
			longint lim;
			ns = n_src > 256 ? 256 : n_src;
			nt = n_tgt > 256 ? 256 : n_tgt;
			hits = 0;
			lim = longint'(1) << 30;
			// skipped: repeated or out-of-range indices
			if (a == b || j == k || a >= ns || b >= ns || j >= nt || k >= nt)
				return;
			ap = seg_angle(longint'(src_pt[b][1]) - src_pt[a][1],
				longint'(src_pt[b][0]) - src_pt[a][0]);
			aq = seg_angle(longint'(tgt_pt[k][1]) - tgt_pt[j][1],
				longint'(tgt_pt[k][0]) - tgt_pt[j][0]);
			yaw = rnd_shift(aq - ap, 8);
			yaw_to_cs(yaw, c, s);
			tx = clamp16(tgt_pt[j][0] - rnd_shift(c * src_pt[a][0] - s * src_pt[a][1], 28));
			ty = clamp16(tgt_pt[j][1] - rnd_shift(s * src_pt[a][0] + c * src_pt[a][1], 28));
			thr2 = longint'(thresh) * thresh;
			for (int m = 0; m < ns; m++) begin
				px = src_pt[m][0];
				py = src_pt[m][1];
				rx = rnd_shift(c * px - s * py, 28) + tx;
				ry = rnd_shift(s * px + c * py, 28) + ty;
				for (int n = 0; n < nt; n++) begin
					dx = rx - tgt_pt[n][0];
					dy = ry - tgt_pt[n][1];
					if (dx > lim || dx < -lim || dy > lim || dy < -lim)
						continue;
					if (dx * dx + dy * dy < thr2) begin
						hits++;
						break;
					end
				end
			end
			// ties keep the older pose
			if (hits > best_count) begin
				best_count = hits;
				best_x = tx;
				best_y = ty;
				best_yaw = yaw;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == CFG_THRESHOLD)
				thresh = val[14:0];
			else if (idx == CFG_SOURCE_COUNT)
				n_src = val[8:0];
			else if (idx == CFG_TARGET_COUNT)
				n_tgt = val[8:0];
		endfunction

		// note an accepted input transfer
		function void note_item(op_t op, logic signed [15:0] x, logic signed [15:0] y,
			logic [7:0] sl, logic [7:0] a, logic [7:0] b, logic [7:0] j, logic [7:0] k);
			pose_t p;
			case (op)
				OP_LOAD_SRC: begin
					src_pt[sl][0] = x;
					src_pt[sl][1] = y;
				end
				OP_LOAD_TGT: begin
					tgt_pt[sl][0] = x;
					tgt_pt[sl][1] = y;
				end
				OP_HYPOTHESIS: score(a, b, j, k);
				default: begin
					p.x = best_x[15:0];
					p.y = best_y[15:0];
					p.yaw = best_yaw[15:0];
					p.count = best_count[8:0];
					pending.push_back(p);
					best_x = 0;
					best_y = 0;
					best_yaw = 0;
					best_count = 0;
				end
			endcase
		endfunction

		// compare one result transfer against the oldest pending pose
		function void check_pose(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] yaw, logic [8:0] count);
			pose_t p;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d yaw=%0d count=%0d",
					$time, x, y, yaw, count);
				errors++;
				return;
			end
			p = pending.pop_front();
			if (x !== p.x) begin
				$display("%0t: pose_x expected %0d actual %0d", $time, p.x, x);
				errors++;
			end
			if (y !== p.y) begin
				$display("%0t: pose_y expected %0d actual %0d", $time, p.y, y);
				errors++;
			end
			if (yaw !== p.yaw) begin
				$display("%0t: pose_yaw expected %0d actual %0d", $time, p.yaw, yaw);
				errors++;
			end
			if (count !== p.count) begin
				$display("%0t: inlier_count expected %0d actual %0d", $time, p.count, count);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          operation;
	logic signed [15:0]  point_x;
	logic signed [15:0]  point_y;
	logic [7:0]          slot;
	logic [7:0]          src_first;
	logic [7:0]          src_second;
	logic [7:0]          tgt_first;
	logic [7:0]          tgt_second;
	logic                done;
	logic signed [15:0]  pose_x;
	logic signed [15:0]  pose_y;
	logic signed [15:0]  pose_yaw;
	logic [8:0]          inlier_count;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [15:0]         cfg_data;

	pose_scoreboard sb;
	bit             gaps_on;
	int             n_items;
	int             cycles;

	ransac_rigid2d_hypothesis_scorer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.point_x(point_x),
		.point_y(point_y),
		.slot(slot),
		.src_first(src_first),
		.src_second(src_second),
		.tgt_first(tgt_first),
		.tgt_second(tgt_second),
		.done(done),
		.pose_x(pose_x),
		.pose_y(pose_y),
		.pose_yaw(pose_yaw),
		.inlier_count(inlier_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// result strobe: sampled before this edge updates the outputs
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pose(pose_x, pose_y, pose_yaw, inlier_count);
	end

	// watchdog, far above two full 256 by 256 hypotheses plus the small ones
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("ransac_rigid2d_hypothesis_scorer regression: fail");
			$finish;
		end
	end

	// random idle burst before a transfer; start stays high when there is none
	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// one input transfer: held until an edge sees start high and busy low
	task automatic send(op_t op, logic signed [15:0] x, logic signed [15:0] y,
		logic [7:0] sl, logic [7:0] a, logic [7:0] b, logic [7:0] j, logic [7:0] k);
		maybe_gap();
		start <= 1'b1;
		operation <= op;
		point_x <= x;
		point_y <= y;
		slot <= sl;
		src_first <= a;
		src_second <= b;
		tgt_first <= j;
		tgt_second <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(op, x, y, sl, a, b, j, k);
		n_items++;
	endtask

	task automatic hyp(logic [7:0] a, logic [7:0] b, logic [7:0] j, logic [7:0] k);
		send(OP_HYPOTHESIS, 16'($urandom), 16'($urandom), 8'($urandom), a, b, j, k);
	endtask

	task automatic finish_item();
		send(OP_FINISH, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// let the block settle: results in, then a hypothesis still running drains
	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write on the config channel, only while the block is idle
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int sx, sy, ns, nt, op_pick;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_LOAD_SRC;
		point_x = '0;
		point_y = '0;
		slot = '0;
		src_first = '0;
		src_second = '0;
		tgt_first = '0;
		tgt_second = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		cycles = 0;
		n_items = 0;
		gaps_on = 1'b1;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill both stores completely: targets are shifted sources with a little
		// noise so hypotheses find inliers; the extreme coordinates sit at the ends
		for (int i = 0; i < 256; i++) begin
			if (i == 0) begin
				sx = -32768;
				sy = 32767;
			end else if (i == 255) begin
				sx = 32767;
				sy = -32768;
			end else begin
				sx = int'($urandom_range(0, 6000)) - 3000;
				sy = int'($urandom_range(0, 6000)) - 3000;
			end
			send(OP_LOAD_SRC, 16'(sx), 16'(sy), 8'(i), 0, 0, 0, 0);
			send(OP_LOAD_TGT, 16'(sx + 300 + int'($urandom_range(0, 20)) - 10),
				16'(sy - 200 + int'($urandom_range(0, 20)) - 10), 8'(i), 0, 0, 0, 0);
		end

		// directed: full stores at reset settings, then repeated indices
		hyp(8'd1, 8'd2, 8'd1, 8'd2);
		hyp(8'd3, 8'd3, 8'd0, 8'd1);
		hyp(8'd0, 8'd1, 8'd5, 8'd5);
		finish_item();
		finish_item();
		settle();

		// counts above the store size saturate; widest threshold, bit 15 dropped
		write_reg(CFG_SOURCE_COUNT, 16'd511);
		write_reg(CFG_TARGET_COUNT, 16'd300);
		write_reg(CFG_THRESHOLD, 16'hFFFF);
		hyp(8'd255, 8'd0, 8'd254, 8'd253);
		finish_item();
		settle();

		// smallest counts, zero threshold, out-of-range index, coincident points
		write_reg(CFG_SOURCE_COUNT, 16'd8);
		write_reg(CFG_TARGET_COUNT, 16'd8);
		write_reg(CFG_THRESHOLD, 16'd0);
		send(OP_LOAD_SRC, 16'sd100, -16'sd40, 8'd6, 0, 0, 0, 0);
		send(OP_LOAD_SRC, 16'sd100, -16'sd40, 8'd7, 0, 0, 0, 0);
		send(OP_LOAD_TGT, -16'sd7, 16'sd9, 8'd6, 0, 0, 0, 0);
		send(OP_LOAD_TGT, -16'sd7, 16'sd9, 8'd7, 0, 0, 0, 0);
		hyp(8'd6, 8'd7, 8'd6, 8'd7);
		hyp(8'd0, 8'd8, 8'd0, 8'd1);
		finish_item();
		settle();
		write_reg(CFG_THRESHOLD, 16'd3000);
		hyp(8'd6, 8'd7, 8'd6, 8'd7);
		// tie: the same hypothesis again must not replace the pose
		hyp(8'd1, 8'd2, 8'd1, 8'd2);
		hyp(8'd1, 8'd2, 8'd1, 8'd2);
		finish_item();
		settle();
		write_reg(CFG_SOURCE_COUNT, 16'd2);
		write_reg(CFG_TARGET_COUNT, 16'd2);
		hyp(8'd0, 8'd1, 8'd1, 8'd0);
		finish_item();
		settle();
		write_reg(CFG_SOURCE_COUNT, 16'd1);
		write_reg(CFG_TARGET_COUNT, 16'd0);
		hyp(8'd0, 8'd1, 8'd0, 8'd1);
		finish_item();
		settle();

		// random phases with small stores; idle bursts off for the last ones
		n_items = 0;
		for (int ph = 0; n_items < 100; ph++) begin
			if (n_items > 80)
				gaps_on = 1'b0;
			ns = $urandom_range(2, 12);
			nt = $urandom_range(2, 12);
			write_reg(CFG_SOURCE_COUNT, 16'(ns));
			write_reg(CFG_TARGET_COUNT, 16'(nt));
			case ($urandom_range(0, 3))
				0: write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 100)));
				1: write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 32767)));
				2: write_reg(CFG_THRESHOLD, 16'($urandom));
				default: write_reg(CFG_THRESHOLD, 16'($urandom_range(20, 400)));
			endcase
			repeat ($urandom_range(6, 14)) begin
				op_pick = $urandom_range(0, 99);
				if (op_pick < 55) begin
					// well formed: distinct indices inside the counts in use
					sx = $urandom_range(0, ns - 1);
					sy = (sx + $urandom_range(1, ns - 1)) % ns;
					op_pick = $urandom_range(0, nt - 1);
					hyp(8'(sx), 8'(sy), 8'(op_pick), 8'((op_pick + $urandom_range(1, nt - 1)) % nt));
				end else if (op_pick < 65) begin
					hyp(8'($urandom), 8'($urandom_range(0, 13)), 8'($urandom_range(0, 13)),
						8'($urandom));
				end else if (op_pick < 80) begin
					if ($urandom_range(0, 1))
						send(OP_LOAD_SRC, 16'($urandom), 16'($urandom), 8'($urandom), 0, 0, 0, 0);
					else
						send(OP_LOAD_TGT, 16'($urandom_range(0, 6000) - 3000),
							16'($urandom_range(0, 6000) - 3000), 8'($urandom_range(0, 15)),
							0, 0, 0, 0);
				end else begin
					finish_item();
				end
			end
			finish_item();
			settle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ransac_rigid2d_hypothesis_scorer regression: pass");
		else
			$display("ransac_rigid2d_hypothesis_scorer regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
